>>> src/pee_pkg.sv
// shared types and constants for the postfix expression evaluator
// no dependencies; used by pee_cell, pee_alu and the top level
`default_nettype none

package pee_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 16;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned STATUS_W = 3;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_STAR  = 8'h2a;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_TOO_LONG   = 3'd1,
        ST_TOO_FEW    = 3'd2,
        ST_INVALID    = 3'd3,
        ST_INCOMPLETE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2
    } t_alu_op;

    // per-cell move: take the word from the cell nearer the top, or the deeper one
    typedef struct packed {
        logic take_up;
        logic take_down;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> src/pee_cell.sv
// one stack cell: holds a word, loads from either neighbour
// depends on pee_pkg
`default_nettype none

module pee_cell (
    input  wire                          i_clk,
    input  wire pee_pkg::t_cell_ctrl     i_ctrl,
    input  wire [pee_pkg::WORD_W-1:0]    i_up,
    input  wire [pee_pkg::WORD_W-1:0]    i_down,
    output logic [pee_pkg::WORD_W-1:0]   o_word
);

    logic [pee_pkg::WORD_W-1:0] r_word;
    logic [pee_pkg::WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctrl.take_up) begin
            n_word = i_up;
        end else if (i_ctrl.take_down) begin
            n_word = i_down;
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

>>> src/pee_alu.sv
// operator unit: second op first, wrapping at word width
// depends on pee_pkg
`default_nettype none

module pee_alu (
    input  wire pee_pkg::t_alu_op        i_op,
    input  wire [pee_pkg::WORD_W-1:0]    i_second,
    input  wire [pee_pkg::WORD_W-1:0]    i_first,
    output logic [pee_pkg::WORD_W-1:0]   o_result
);

    always_comb begin
        case (i_op)
            pee_pkg::ALU_ADD: o_result = i_second + i_first;
            pee_pkg::ALU_SUB: o_result = i_second - i_first;
            pee_pkg::ALU_MUL: o_result = i_second * i_first;
            default:          o_result = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> src/postfix_expression_evaluator.sv
// postfix evaluator: one character word per cycle while the skid slot is free, on a row of stack cells
// latency: a result word is on the outputs the cycle after its end marker or error,
//   later only while the output is held
// throughput: one input word every cycle; the input stalls only while a second result
//   word is parked in the skid slot behind the output word
// reset: clears the stack count, error flag and both output slots; cell words are not cleared
`default_nettype none

module postfix_expression_evaluator #(
    parameter int unsigned STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire                                 i_op,
    input  wire  [7:0]                          i_char_code,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [pee_pkg::STATUS_W-1:0]        o_status,
    output logic signed [pee_pkg::WORD_W-1:0]   o_value
);

    // depends on pee_pkg, pee_cell, pee_alu
    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_C = CNT_W'(2);

    // control registers
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_err, n_err;

    // output slot and skid slot
    logic                        r_out_valid, n_out_valid;
    pee_pkg::t_status            r_out_status, n_out_status;
    logic [pee_pkg::WORD_W-1:0]  r_out_value, n_out_value;
    logic                        r_skid_valid, n_skid_valid;
    pee_pkg::t_status            r_skid_status, n_skid_status;
    logic [pee_pkg::WORD_W-1:0]  r_skid_value, n_skid_value;

    // decoded word
    logic                        w_accept;
    logic                        w_is_digit;
    logic                        w_is_oper;
    pee_pkg::t_alu_op            w_alu_op;
    logic                        w_push;
    logic                        w_binop;
    logic                        w_res_valid;
    pee_pkg::t_status            w_res_status;
    logic [pee_pkg::WORD_W-1:0]  w_res_value;
    logic [pee_pkg::WORD_W-1:0]  w_alu_result;
    logic [pee_pkg::WORD_W-1:0]  w_top_in;
    logic [3:0]                  w_digit;

    // cell row, index 0 is top of stack
    logic [pee_pkg::WORD_W-1:0]  w_word [STACK_DEPTH];
    pee_pkg::t_cell_ctrl         w_ctrl [STACK_DEPTH];

    // a new word is taken as long as the skid slot is free
    assign o_in_ready = !r_skid_valid;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_is_digit = (i_char_code >= pee_pkg::CH_ZERO) && (i_char_code <= pee_pkg::CH_NINE);
    assign w_is_oper  = (i_char_code == pee_pkg::CH_PLUS) || (i_char_code == pee_pkg::CH_MINUS)
                        || (i_char_code == pee_pkg::CH_STAR);
    assign w_digit    = 4'(i_char_code - pee_pkg::CH_ZERO);

    always_comb begin
        case (i_char_code)
            pee_pkg::CH_PLUS:  w_alu_op = pee_pkg::ALU_ADD;
            pee_pkg::CH_MINUS: w_alu_op = pee_pkg::ALU_SUB;
            default:           w_alu_op = pee_pkg::ALU_MUL;
        endcase
    end

    pee_alu u_alu (
        .i_op     (w_alu_op),
        .i_second (w_word[1]),
        .i_first  (w_word[0]),
        .o_result (w_alu_result)
    );

    // stack count, error flag and result of this word
    always_comb begin
        n_count      = r_count;
        n_err        = r_err;
        w_push       = 1'b0;
        w_binop      = 1'b0;
        w_res_valid  = 1'b0;
        w_res_status = pee_pkg::ST_OK;
        w_res_value  = '0;
        if (w_accept) begin
            if (i_op) begin
                // end marker: report unless an error was already given, then clear
                if (!r_err) begin
                    w_res_valid = 1'b1;
                    if (r_count == '0) begin
                        w_res_status = pee_pkg::ST_TOO_FEW;
                    end else if (r_count > ONE_C) begin
                        w_res_status = pee_pkg::ST_INCOMPLETE;
                    end else begin
                        w_res_value = w_word[0];
                    end
                end
                n_count = '0;
                n_err   = 1'b0;
            end else if (!r_err) begin
                if (w_is_digit) begin
                    if (r_count >= DEPTH_C) begin
                        w_res_valid  = 1'b1;
                        w_res_status = pee_pkg::ST_TOO_LONG;
                        n_err        = 1'b1;
                    end else begin
                        w_push  = 1'b1;
                        n_count = r_count + ONE_C;
                    end
                end else if (w_is_oper) begin
                    if (r_count < TWO_C) begin
                        w_res_valid  = 1'b1;
                        w_res_status = pee_pkg::ST_TOO_FEW;
                        n_err        = 1'b1;
                    end else begin
                        w_binop = 1'b1;
                        n_count = r_count - ONE_C;
                    end
                end else begin
                    w_res_valid  = 1'b1;
                    w_res_status = pee_pkg::ST_INVALID;
                    n_err        = 1'b1;
                end
            end
        end
    end

    // push shifts every cell down; an operator puts its result in the top
    // cell and pulls the deeper cells up by one
    assign w_top_in = w_push ? {{(pee_pkg::WORD_W-4){1'b0}}, w_digit} : w_alu_result;

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [pee_pkg::WORD_W-1:0] w_up;
        logic [pee_pkg::WORD_W-1:0] w_down;

        if (g == 0) begin : g_top
            assign w_up              = w_top_in;
            assign w_ctrl[g].take_up = w_push || w_binop;
        end else begin : g_mid
            assign w_up              = w_word[g-1];
            assign w_ctrl[g].take_up = w_push;
        end

        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_down = w_word[g];
        end else begin : g_inner
            assign w_down = w_word[g+1];
        end

        if (g == 0) begin : g_top_down
            assign w_ctrl[g].take_down = 1'b0;
        end else begin : g_rest_down
            assign w_ctrl[g].take_down = w_binop;
        end

        pee_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl[g]),
            .i_up   (w_up),
            .i_down (w_down),
            .o_word (w_word[g])
        );
    end

    // output slot with skid behind it
    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_value   = r_out_value;
        n_skid_valid  = r_skid_valid;
        n_skid_status = r_skid_status;
        n_skid_value  = r_skid_value;
        if (r_out_valid && !i_out_ready) begin
            // output held: a fresh result parks in the skid slot
            if (w_res_valid) begin
                n_skid_valid  = 1'b1;
                n_skid_status = w_res_status;
                n_skid_value  = w_res_value;
            end
        end else if (r_skid_valid) begin
            n_out_valid   = 1'b1;
            n_out_status  = r_skid_status;
            n_out_value   = r_skid_value;
            n_skid_valid  = 1'b0;
        end else begin
            n_out_valid   = w_res_valid;
            n_out_status  = w_res_status;
            n_out_value   = w_res_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_err        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_err        <= n_err;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_status  <= n_out_status;
        r_out_value   <= n_out_value;
        r_skid_status <= n_skid_status;
        r_skid_value  <= n_skid_value;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value     = $signed(r_out_value);

    // count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("stack count above depth");

    // skid slot only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    // an accepted end marker leaves an empty, error-free stack
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op) |=> (r_count == '0 && !r_err))
        else $error("end marker did not clear the stack");

    // characters arriving after an error leave the stack alone
    a_err_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_op && r_err) |=> ($stable(r_count) && r_err))
        else $error("stack moved while an error was latched");

    // a result never arrives while the skid slot is occupied
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !w_res_valid)
        else $error("result word with no free slot");

endmodule

`default_nettype wire
